// File: hdl/html_to_plain_text_filter_unit_defines.svh
// Assertion helpers; expect clk and rst_n in scope.
`ifndef HTML_TO_PLAIN_TEXT_FILTER_UNIT_DEFINES_SVH
`define HTML_TO_PLAIN_TEXT_FILTER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define HTF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define HTF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/htf_pkg.sv
`default_nettype none
package htf_pkg;

    localparam int LA_DEPTH    = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int ENT_COUNT   = 101;
    localparam int ENT_ASCII_COUNT = 6;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_H     = 8'h68;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0A;

    // One decided head byte: up to four output bytes.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      cnt;
        logic            flush;
        logic            fin;
    } htf_rec_t;

    localparam logic [63:0] ENT_NAME [ENT_COUNT] = '{
        "&amp;", "&lt;", "&gt;", "&quot;", "&apos;", "&nbsp;",
        "&iexcl;", "&cent;", "&pound;", "&curren;", "&yen;", "&brvbar;", "&sect;",
        "&uml;", "&copy;", "&ordf;", "&laquo;", "&not;", "&shy;", "&reg;", "&macr;",
        "&deg;", "&plusmn;", "&sup2;", "&sup3;", "&acute;", "&micro;", "&para;",
        "&middot;", "&cedil;", "&sup1;", "&ordm;", "&raquo;", "&frac14;",
        "&frac12;", "&frac34;", "&iquest;", "&Agrave;", "&Aacute;", "&Acirc;",
        "&Atilde;", "&Auml;", "&Aring;", "&AElig;", "&Ccedil;", "&Egrave;",
        "&Eacute;", "&Ecirc;", "&Euml;", "&Igrave;", "&Iacute;", "&Icirc;",
        "&Iuml;", "&ETH;", "&Ntilde;", "&Ograve;", "&Oacute;", "&Ocirc;",
        "&Otilde;", "&Ouml;", "&times;", "&Oslash;", "&Ugrave;", "&Uacute;",
        "&Ucirc;", "&Uuml;", "&Yacute;", "&THORN;", "&szlig;", "&agrave;",
        "&aacute;", "&acirc;", "&atilde;", "&auml;", "&aring;", "&aelig;",
        "&ccedil;", "&egrave;", "&eacute;", "&ecirc;", "&euml;", "&igrave;",
        "&iacute;", "&icirc;", "&iuml;", "&eth;", "&ntilde;", "&ograve;",
        "&oacute;", "&ocirc;", "&otilde;", "&ouml;", "&divide;", "&oslash;",
        "&ugrave;", "&uacute;", "&ucirc;", "&uuml;", "&yacute;", "&thorn;",
        "&yuml;"
    };

    // Name length: count of nonzero bytes (names are right-justified).
    function automatic logic [3:0] ent_len(input logic [63:0] s);
        logic [3:0] n;
        n = '0;
        for (int k = 0; k < 8; k++) begin
            if (s[8*k +: 8] != 8'h00) begin
                n = n + 4'd1;
            end
        end
        return n;
    endfunction

    // Character k of a name, counted from its first byte.
    function automatic logic [7:0] ent_char(input logic [63:0] s, input int k);
        logic [63:0] t;
        int          sh;
        sh = 8 * (int'(ent_len(s)) - 1 - k);
        t  = (sh >= 0) ? (s >> sh) : 64'd0;
        return t[7:0];
    endfunction

    function automatic logic [7:0] ent_ascii(input logic [6:0] idx);
        logic [7:0] c;
        case (idx)
            7'd0:    c = 8'h26;
            7'd1:    c = 8'h3C;
            7'd2:    c = 8'h3E;
            7'd3:    c = 8'h22;
            7'd4:    c = 8'h27;
            default: c = 8'h20;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// File: hdl/htf_in_if.sv
`default_nettype none
interface htf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface
`default_nettype wire

// File: hdl/htf_out_if.sv
`default_nettype none
interface htf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;

    modport source (output valid, output out_byte, output out_valid, output out_last,
                    input ready);
    modport sink   (input valid, input out_byte, input out_valid, input out_last,
                    output ready);
endinterface
`default_nettype wire

// File: hdl/htf_front.sv
`default_nettype none
`include "html_to_plain_text_filter_unit_defines.svh"
module htf_front
    import htf_pkg::*;
#(
    parameter int D = LA_DEPTH
)(
    input  wire logic  clk,
    input  wire logic  rst_n,
    htf_in_if.sink     in_ch,
    output htf_rec_t   rec,
    output logic       rec_push,
    input  wire logic  q_full
);
    localparam int AW = $clog2(D + 1);

    logic [7:0]    win_reg [D];
    logic [7:0]    win_next [D];
    logic [AW-1:0] fill_reg, fill_next;
    logic          tag_reg, tag_next;
    logic [7:0]    prev_reg, prev_next;
    logic          started_reg, started_next;
    logic [2:0]    skip_reg, skip_next;
    logic          flush_reg, flush_next;

    logic [7:0]    wv [D];
    logic [AW-1:0] avail;
    logic          more, accept, do_pop, final_pop;
    logic          has_next, has_three;
    logic [7:0]    c, n1, n2;
    logic          ent_hit;
    logic [6:0]    ent_idx;
    logic [3:0]    ent_l;
    logic [7:0]    cp;
    logic [3:0][7:0] ob;
    logic [2:0]    ocnt;

    assign in_ch.ready = !flush_reg && !q_full;
    assign accept      = in_ch.valid && in_ch.ready;
    assign more        = !flush_reg;
    assign avail       = flush_reg ? fill_reg : fill_reg + AW'(1);
    assign final_pop   = flush_reg && (fill_reg == AW'(1));
    assign do_pop      = flush_reg ? !q_full
                                   : (accept && !in_ch.in_last && fill_reg == AW'(D - 1));

    always_comb
    begin
        for (int k = 0; k < D; k++) begin
            wv[k] = (!flush_reg && fill_reg == AW'(k)) ? in_ch.in_byte : win_reg[k];
        end
    end

    // Parallel compare against every table entry; names never prefix each other.
    always_comb
    begin : ent_match
        logic ok;
        ent_hit = 1'b0;
        ent_idx = '0;
        ent_l   = '0;
        for (int e = ENT_COUNT - 1; e >= 0; e--) begin
            ok = 1'b1;
            for (int k = 0; k < 8; k++) begin
                if (k < int'(ent_len(ENT_NAME[e]))) begin
                    if (!(avail > AW'(k)) || wv[k] != ent_char(ENT_NAME[e], k)) begin
                        ok = 1'b0;
                    end
                end
            end
            if (ok) begin
                ent_hit = 1'b1;
                ent_idx = 7'(e);
                ent_l   = ent_len(ENT_NAME[e]);
            end
        end
    end

    assign cp = 8'hA1 + 8'(ent_idx) - 8'(ENT_ASCII_COUNT);

    always_comb
    begin
        c         = wv[0];
        has_next  = more || (avail > AW'(1));
        has_three = more || (avail > AW'(3));
        n1        = (avail > AW'(1)) ? wv[1] : 8'h00;
        n2        = (avail > AW'(2)) ? wv[2] : 8'h00;

        ob        = '0;
        ocnt      = '0;
        tag_next  = tag_reg;
        skip_next = skip_reg;

        if (skip_reg != 3'd0) begin
            skip_next = skip_reg - 3'd1;
        end else if (c == CH_LT) begin
            tag_next = 1'b1;
            if (has_three && n1 == CH_SLASH) begin
                if (n2 == CH_H) begin
                    ob   = {8'h00, 8'h00, CH_LF, CH_SP};
                    ocnt = 3'd2;
                end
            end else if (has_three && (n1 == CH_P || n1 == CH_H)) begin
                ob   = {CH_LF, CH_SP, CH_LF, CH_SP};
                ocnt = 3'd4;
            end
        end else if (c == CH_GT) begin
            tag_next = 1'b0;
        end else if (c == CH_LF && (!started_reg || prev_reg != CH_LF ||
                                    !has_next || n1 != CH_LF)) begin
            // lone newline dropped
        end else if (c == CH_SP && (!started_reg || prev_reg == CH_SP ||
                                    prev_reg == CH_LF)) begin
            // space run collapsed
        end else if (!tag_reg) begin
            if (c == CH_AMP && ent_hit) begin
                skip_next = 3'(ent_l - 4'd1);
                if (ent_idx < 7'(ENT_ASCII_COUNT)) begin
                    ob   = {8'h00, 8'h00, 8'h00, ent_ascii(ent_idx)};
                    ocnt = 3'd1;
                end else begin
                    ob   = {8'h00, 8'h00, 8'h80 | {2'b00, cp[5:0]},
                            (cp < 8'hC0) ? 8'hC2 : 8'hC3};
                    ocnt = 3'd2;
                end
            end else begin
                ob   = {8'h00, 8'h00, 8'h00, c};
                ocnt = 3'd1;
            end
        end
    end

    assign rec.bytes = ob;
    assign rec.cnt   = ocnt;
    assign rec.flush = flush_reg;
    assign rec.fin   = final_pop;
    assign rec_push  = do_pop && (ocnt != 3'd0 || final_pop);

    always_comb
    begin
        win_next     = win_reg;
        fill_next    = fill_reg;
        prev_next    = prev_reg;
        started_next = started_reg;
        flush_next   = flush_reg;
        if (do_pop) begin
            for (int k = 0; k < D - 1; k++) begin
                win_next[k] = wv[k + 1];
            end
            win_next[D-1] = 8'h00;
            fill_next     = avail - AW'(1);
            if (ocnt != 3'd0) begin
                prev_next    = ob[ocnt[1:0] - 2'd1];
                started_next = 1'b1;
            end
            if (final_pop) begin
                for (int k = 0; k < D; k++) begin
                    win_next[k] = 8'h00;
                end
                fill_next    = '0;
                prev_next    = 8'h00;
                started_next = 1'b0;
                flush_next   = 1'b0;
            end
        end else if (accept) begin
            win_next   = wv;
            fill_next  = avail;
            flush_next = in_ch.in_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int k = 0; k < D; k++) begin
                win_reg[k] <= 8'h00;
            end
            fill_reg    <= '0;
            tag_reg     <= 1'b0;
            prev_reg    <= 8'h00;
            started_reg <= 1'b0;
            skip_reg    <= '0;
            flush_reg   <= 1'b0;
        end else begin
            win_reg     <= win_next;
            fill_reg    <= fill_next;
            prev_reg    <= prev_next;
            started_reg <= started_next;
            flush_reg   <= flush_next;
            if (do_pop) begin
                tag_reg  <= final_pop ? 1'b0 : tag_next;
                skip_reg <= final_pop ? 3'd0 : skip_next;
            end
        end
    end

    `HTF_ASSERT_IMP(a_fill_bound, !flush_reg, fill_reg <= AW'(D - 1),
                    "window overfilled outside flush")
    `HTF_ASSERT_NXT(a_flush_done, flush_reg && fill_reg == AW'(1) && !q_full,
                    !flush_reg && fill_reg == '0, "flush did not end on last pop")

endmodule
`default_nettype wire

// File: hdl/htf_queue.sv
`default_nettype none
`include "html_to_plain_text_filter_unit_defines.svh"
module htf_queue
    import htf_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire htf_rec_t wr_data,
    input  wire logic     push,
    input  wire logic     pop,
    output htf_rec_t      head,
    output logic          full,
    output logic          empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    htf_rec_t      mem_reg [DEPTH];
    logic [PW-1:0] wr_reg, rd_reg;
    logic [CW-1:0] cnt_reg;

    assign full  = (cnt_reg == CW'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + PW'(1);
            end
            if (pop) begin
                rd_reg <= (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + PW'(1);
            end
            cnt_reg <= cnt_reg + CW'(push) - CW'(pop);
        end
    end

    `HTF_ASSERT_IMP(a_no_overflow, push, !full || pop, "push into full queue")
    `HTF_ASSERT_IMP(a_no_underflow, pop, !empty, "pop from empty queue")

endmodule
`default_nettype wire

// File: hdl/htf_back.sv
`default_nettype none
`include "html_to_plain_text_filter_unit_defines.svh"
module htf_back
    import htf_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire htf_rec_t head,
    input  wire logic     q_empty,
    output logic          q_pop,
    htf_out_if.source     out_ch
);
    logic [1:0] idx_reg;
    logic       pv_reg, pv_next;
    logic [7:0] pb_reg, pb_next;
    logic       ov_reg, ovld_reg, olast_reg;
    logic [7:0] ob_reg;

    logic       ev, can_out, load, consume;
    logic       end_tok, rec_end, e_final;
    logic [7:0] e_byte, ld_byte;
    logic       ld_vld, ld_last;

    assign ev      = !q_empty;
    assign can_out = !ov_reg || out_ch.ready;
    assign end_tok = (head.cnt == 3'd0);
    assign rec_end = end_tok || ({1'b0, idx_reg} == head.cnt - 3'd1);
    assign e_final = head.fin && rec_end;
    assign e_byte  = head.bytes[idx_reg];
    assign q_pop   = consume && rec_end;

    // Flush bytes wait one deep in the hold stage so the end mark can tag the last one.
    always_comb
    begin
        load    = 1'b0;
        consume = 1'b0;
        pv_next = pv_reg;
        pb_next = pb_reg;
        ld_byte = e_byte;
        ld_vld  = 1'b1;
        ld_last = 1'b0;
        if (ev) begin
            if (!head.flush) begin
                if (can_out) begin
                    load    = 1'b1;
                    consume = 1'b1;
                end
            end else if (end_tok) begin
                if (can_out) begin
                    load    = 1'b1;
                    consume = 1'b1;
                    ld_last = 1'b1;
                    if (pv_reg) begin
                        ld_byte = pb_reg;
                        pv_next = 1'b0;
                    end else begin
                        ld_byte = 8'h00;
                        ld_vld  = 1'b0;
                    end
                end
            end else if (!e_final) begin
                if (!pv_reg) begin
                    pv_next = 1'b1;
                    pb_next = e_byte;
                    consume = 1'b1;
                end else if (can_out) begin
                    load    = 1'b1;
                    ld_byte = pb_reg;
                    pb_next = e_byte;
                    consume = 1'b1;
                end
            end else begin
                if (!pv_reg) begin
                    if (can_out) begin
                        load    = 1'b1;
                        ld_last = 1'b1;
                        consume = 1'b1;
                    end
                end else if (can_out) begin
                    load    = 1'b1;
                    ld_byte = pb_reg;
                    pv_next = 1'b0;
                end
            end
        end
    end

    assign out_ch.valid     = ov_reg;
    assign out_ch.out_byte  = ob_reg;
    assign out_ch.out_valid = ovld_reg;
    assign out_ch.out_last  = olast_reg;

    always_ff @(posedge clk)
    begin
        pb_reg <= pb_next;
        if (load) begin
            ob_reg    <= ld_byte;
            ovld_reg  <= ld_vld;
            olast_reg <= ld_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg <= '0;
            pv_reg  <= 1'b0;
            ov_reg  <= 1'b0;
        end else begin
            pv_reg <= pv_next;
            if (consume) begin
                idx_reg <= rec_end ? 2'd0 : idx_reg + 2'd1;
            end
            if (load) begin
                ov_reg <= 1'b1;
            end else if (out_ch.ready) begin
                ov_reg <= 1'b0;
            end
        end
    end

    `HTF_ASSERT_IMP(a_hold_empty, ev && !head.flush, !pv_reg,
                    "held flush byte while streaming")
    `HTF_ASSERT_IMP(a_bare_is_last, ov_reg && !ovld_reg, olast_reg,
                    "bare marker without last")

endmodule
`default_nettype wire

// File: hdl/html_to_plain_text_filter_unit.sv
// A byte is decided once LOOKAHEAD_DEPTH-1 later bytes are in; its text then passes the
// queue, written on that transaction, then the output register. Throughput: one input
// transaction per cycle while the queue has room; output one byte per cycle while out_ch
// is ready, so tags that expand to four bytes hold the input back through the four-entry
// queue. End of document: after in_last the window drains one byte per cycle while the
// queue has room, with ready low. Reset (rst_n, async, low) empties everything.
`default_nettype none
module html_to_plain_text_filter_unit
    import htf_pkg::*;
#(
    parameter int LOOKAHEAD_DEPTH = LA_DEPTH,
    parameter int QDEPTH          = QUEUE_DEPTH
)(
    input  wire logic clk,
    input  wire logic rst_n,
    htf_in_if.sink    in_ch,
    htf_out_if.source out_ch
);
    // Front: lookahead window, tag/space/entity decisions, a record per emitting byte.
    // Queue: decouples the decide rate from the byte-serial output side.
    // Back: unrolls each record into output transactions, tags the final one.
    htf_rec_t rec, head;
    logic     rec_push, q_pop, q_full, q_empty;

    htf_front #(
        .D(LOOKAHEAD_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .rec      (rec),
        .rec_push (rec_push),
        .q_full   (q_full)
    );

    htf_queue #(
        .DEPTH(QDEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_data (rec),
        .push    (rec_push),
        .pop     (q_pop),
        .head    (head),
        .full    (q_full),
        .empty   (q_empty)
    );

    htf_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .out_ch  (out_ch)
    );

endmodule
`default_nettype wire
